[rtl/core/tbrat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrat_pkg: shared types and constants
// Payload structs and fixed constants of the tick bar tracker.
// ----------------------------------------------------------------------------
package tbrat_pkg;
  localparam int PRICE_BITS = 32;
  localparam int TIME_W = 48;
  localparam int PERIOD_W = 22;
  localparam int BARS_W = 6;
  localparam int RSI_W = 23;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 22'd60000;
  localparam logic [BARS_W-1:0] BAR_CAP = 6'd50;
  localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;
  localparam logic [RSI_W-1:0] RSI_MID = 23'd3276800;

  typedef struct packed {
    logic [PRICE_BITS-1:0] bid_price;
    logic [PRICE_BITS-1:0] ask_price;
    logic [TIME_W-1:0]     time_ms;
  } tick_t;

  typedef struct packed {
    logic                  bar_closed;
    logic [PRICE_BITS-1:0] closed_high;
    logic [PRICE_BITS-1:0] closed_low;
    logic [PRICE_BITS-1:0] closed_close;
    logic [BARS_W-1:0]     bars_held;
    logic [PRICE_BITS-1:0] range_average;
    logic [RSI_W-1:0]      strength_index;
  } result_t;
endpackage

[rtl/core/tbrat_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrat_tick_if / tbrat_result_if: valid/ready channels
// One beat carries one tick or one result.
// ----------------------------------------------------------------------------
interface tbrat_tick_if;
  logic valid;
  logic ready;
  tbrat_pkg::tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbrat_result_if;
  logic valid;
  logic ready;
  tbrat_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tbrat_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrat_divider: bit-serial restoring divider
// One quotient bit per cycle; numerator shifts in MSB first.
// ----------------------------------------------------------------------------
module tbrat_divider #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic             busy;
  logic [NUM_W-1:0] shreg;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial = {rem[DEN_W-1:0], shreg[NUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
        shreg <= num;
        dreg <= den;
        rem <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dreg}) begin
          rem <= trial - {1'b0, dreg};
          shreg <= {shreg[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          shreg <= {shreg[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = shreg;
endmodule

[rtl/core/tick_bar_rsi_atr_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_bar_rsi_atr_tracker: tick bars with tick RSI and bar ATR
// Per tick, the shared bit-serial divider computes the bar index and, when
//   needed, the RSI and ATR; a bit-serial multiply runs ahead of the RSI divide.
// Throughput: one tick at a time; the next tick is
//   taken as soon as the result is loaded, stalls only if it is still held.
// Reset (rst, synchronous): rings, sums and counts clear, RSI to 50,
//   period to 60000 ms.
// ----------------------------------------------------------------------------
module tick_bar_rsi_atr_tracker #(
  parameter int RSI_WINDOW = 14,
  parameter int ATR_WINDOW = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbrat_pkg::PERIOD_W-1:0] cfg_wdata,
  tbrat_tick_if.sink                    tick,
  tbrat_result_if.source                result
);
  import tbrat_pkg::*;

  localparam int RP_W = $clog2(RSI_WINDOW);
  localparam int AP_W = (ATR_WINDOW > 1) ? $clog2(ATR_WINDOW) : 1;
  localparam int MC_W = $clog2(RSI_WINDOW + 1);
  localparam int SUM_W = PRICE_BITS + 7;
  // wide enough for gain*6553600 and for the tick time
  localparam int DIV_W = (SUM_W + RSI_W > TIME_W) ? SUM_W + RSI_W : TIME_W;
  localparam int DEN_W = SUM_W + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIDX  = 3'd1;
  localparam logic [2:0] S_RSI   = 3'd2;
  localparam logic [2:0] S_RSIW  = 3'd3;
  localparam logic [2:0] S_BAR   = 3'd4;
  localparam logic [2:0] S_ATRW  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [PERIOD_W-1:0] period;

  logic [PRICE_BITS-1:0] gain_ring [RSI_WINDOW];
  logic [PRICE_BITS-1:0] loss_ring [RSI_WINDOW];
  logic [PRICE_BITS-1:0] tr_ring [ATR_WINDOW];
  logic [SUM_W-1:0] gain_sum, loss_sum, tr_sum;
  logic [MC_W-1:0] move_count;
  logic [RP_W-1:0] rptr;
  logic [AP_W-1:0] aptr;
  logic [PRICE_BITS-1:0] prev_mid, hi, lo, cl, prior_close, mid;
  logic have_prev, bar_started;
  logic [TIME_W-1:0] bar_idx, new_idx;
  logic [BARS_W-1:0] closed_count;
  logic [PRICE_BITS-1:0] atr;
  logic [RSI_W-1:0] rsi;
  logic [PRICE_BITS-1:0] b_reg, a_reg;
  logic closed;
  logic [PRICE_BITS-1:0] c_hi, c_lo, c_cl;
  logic out_valid;
  result_t out_data;

  // divider, shared for bar index, RSI and ATR
  logic div_start, div_done;
  logic [DIV_W-1:0] dnum, dquo;
  logic [DEN_W-1:0] dden;
  tbrat_divider #(.NUM_W(DIV_W), .DEN_W(DEN_W)) u_div (
    .clk, .rst, .start(div_start), .num(dnum), .den(dden),
    .done(div_done), .quo(dquo)
  );

  // RSI path: gain*6553600 built by a serial multiply, then divided by
  // gain+loss; the product always fits DIV_W bits
  logic [PRICE_BITS:0] msum;
  logic [PRICE_BITS-1:0] g_new, l_new, tr_val, d1, d2, spread;
  logic [SUM_W-1:0] gsum_n, lsum_n;
  logic [MC_W-1:0] mc_n;
  logic [5:0] held;

  assign msum = {1'b0, b_reg} + {1'b0, a_reg};
  assign g_new = (mid > prev_mid) ? mid - prev_mid : '0;
  assign l_new = (mid < prev_mid) ? prev_mid - mid : '0;
  assign gsum_n = gain_sum - SUM_W'(gain_ring[rptr]) + SUM_W'(g_new);
  assign lsum_n = loss_sum - SUM_W'(loss_ring[rptr]) + SUM_W'(l_new);
  assign mc_n = (move_count < MC_W'(RSI_WINDOW)) ? move_count + 1'b1 : move_count;
  assign spread = hi - lo;
  assign d1 = (hi >= prior_close) ? hi - prior_close : prior_close - hi;
  assign d2 = (lo >= prior_close) ? lo - prior_close : prior_close - lo;
  always_comb begin
    tr_val = spread;
    if (d1 > tr_val) tr_val = d1;
    if (d2 > tr_val) tr_val = d2;
  end
  assign held = (closed_count > 6'(ATR_WINDOW)) ? 6'(ATR_WINDOW) : closed_count;

  // bit-serial multiply gain*FULL: shift-add one multiplier bit a cycle
  logic [DIV_W-1:0] prod, prod_next;
  logic [4:0] mcnt;
  logic [RSI_W-1:0] mplr;

  assign prod_next = {prod[DIV_W-2:0], 1'b0} +
                     (mplr[RSI_W-1] ? DIV_W'(gain_sum) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      period <= PERIOD_RESET;
      gain_sum <= '0; loss_sum <= '0; tr_sum <= '0;
      move_count <= '0; rptr <= '0; aptr <= '0;
      have_prev <= 1'b0; bar_started <= 1'b0;
      prev_mid <= '0; prior_close <= '0;
      closed_count <= '0; atr <= '0; rsi <= RSI_MID;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      for (int i = 0; i < RSI_WINDOW; i++) begin
        gain_ring[i] <= '0;
        loss_ring[i] <= '0;
      end
      for (int i = 0; i < ATR_WINDOW; i++) tr_ring[i] <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) period <= cfg_wdata;
      if (out_valid && result.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            b_reg <= tick.data.bid_price;
            a_reg <= tick.data.ask_price;
            dnum <= DIV_W'(tick.data.time_ms);
            dden <= DEN_W'((period == '0) ? PERIOD_W'(1) : period);
            div_start <= 1'b1;
            state <= S_BIDX;
          end
        end
        S_BIDX: begin
          if (div_done) begin
            new_idx <= dquo[TIME_W-1:0];
            mid <= msum[PRICE_BITS:1];
            state <= S_RSI;
          end
        end
        S_RSI: begin
          if (have_prev) begin
            gain_sum <= gsum_n; loss_sum <= lsum_n;
            gain_ring[rptr] <= g_new; loss_ring[rptr] <= l_new;
            rptr <= (32'(rptr) + 1 >= RSI_WINDOW) ? '0 : rptr + 1'b1;
            move_count <= mc_n;
          end
          prev_mid <= mid;
          have_prev <= 1'b1;
          if (have_prev && mc_n >= MC_W'(RSI_WINDOW)) begin
            if (lsum_n == '0) begin
              rsi <= RSI_FULL;
              state <= S_BAR;
            end else begin
              prod <= '0;
              mplr <= RSI_FULL;
              mcnt <= 5'd23;
              dden <= DEN_W'(gsum_n) + DEN_W'(lsum_n);
              state <= S_RSIW;
            end
          end else begin
            state <= S_BAR;
          end
        end
        S_RSIW: begin
          // multiply phase, then divide phase
          if (mcnt != '0) begin
            prod <= prod_next;
            mplr <= {mplr[RSI_W-2:0], 1'b0};
            mcnt <= mcnt - 1'b1;
            if (mcnt == 5'd1) begin
              dnum <= prod_next;
              div_start <= 1'b1;
            end
          end else if (div_start) begin
            div_start <= 1'b0;
          end else if (div_done) begin
            rsi <= dquo[RSI_W-1:0];
            state <= S_BAR;
          end
        end
        S_BAR: begin
          closed <= 1'b0;
          c_hi <= '0; c_lo <= '0; c_cl <= '0;
          if (!bar_started) begin
            hi <= mid; lo <= mid; cl <= mid; bar_idx <= new_idx;
            bar_started <= 1'b1;
            state <= S_OUT;
          end else if (new_idx != bar_idx) begin
            closed <= 1'b1;
            c_hi <= hi; c_lo <= lo; c_cl <= cl;
            prior_close <= cl;
            if (closed_count < BAR_CAP) closed_count <= closed_count + 1'b1;
            hi <= mid; lo <= mid; cl <= mid; bar_idx <= new_idx;
            if (closed_count != '0) begin
              tr_sum <= tr_sum - SUM_W'(tr_ring[aptr]) + SUM_W'(tr_val);
              tr_ring[aptr] <= tr_val;
              aptr <= (32'(aptr) + 1 >= ATR_WINDOW) ? '0 : aptr + 1'b1;
              dnum <= DIV_W'(tr_sum - SUM_W'(tr_ring[aptr]) + SUM_W'(tr_val));
              dden <= DEN_W'(held);
              div_start <= 1'b1;
              state <= S_ATRW;
            end else begin
              state <= S_OUT;
            end
          end else begin
            if (mid > hi) hi <= mid;
            if (mid < lo) lo <= mid;
            cl <= mid;
            state <= S_OUT;
          end
        end
        S_ATRW: begin
          if (div_done) begin
            atr <= dquo[PRICE_BITS-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // wait here while the previous result beat is still held
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_data.bar_closed <= closed;
            out_data.closed_high <= c_hi;
            out_data.closed_low <= c_lo;
            out_data.closed_close <= c_cl;
            out_data.bars_held <= closed_count;
            out_data.range_average <= atr;
            out_data.strength_index <= rsi;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tick.ready = (state == S_IDLE) && !rst;
  assign result.valid = out_valid;
  assign result.data = out_data;
endmodule

[rtl/core/tbrat_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrat_checker: port-level checks of the tracker
// Watches result beats and the tick handshake.
// ----------------------------------------------------------------------------
module tbrat_checker (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic res_valid,
  input logic res_ready,
  input tbrat_pkg::result_t res_data
);
  import tbrat_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped while stalled");
  a_open: assert property (@(posedge clk) disable iff (rst)
    !res_data.bar_closed && res_valid |-> res_data.closed_high == '0)
    else $error("closed fields nonzero without close");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.bars_held <= BAR_CAP)
    else $error("bar count over cap");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick taken while busy");
endmodule

bind tick_bar_rsi_atr_tracker tbrat_checker u_chk (
  .clk, .rst, .tick_valid(tick.valid), .tick_ready(tick.ready),
  .res_valid(result.valid), .res_ready(result.ready), .res_data(result.data)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for tick_bar_rsi_atr_tracker
// Drives quote ticks through the tick channel and checks every result beat
// as a whole, against a cycle-free predictor of the bar, RSI and ATR
// logic. Runs directed corner cases, then random sessions with and without back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import tbrat_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  tbrat_tick_if   tick_ch ();
  tbrat_result_if res_ch ();

  tick_bar_rsi_atr_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick      (tick_ch.sink),
    .result    (res_ch.source)
  );

  localparam int WIN       = 14;
  localparam int DRAIN_CYC = 400;     // beyond worst-case tick latency
  localparam int WDOG_LIM  = 20000;   // covers long hold-off plus latency
  localparam int EXP_DEPTH = 1024;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- predictor state ----
  logic [21:0] period_reg;
  logic [31:0] gain_q [WIN];
  logic [31:0] loss_q [WIN];
  logic [31:0] range_q [WIN];
  logic [35:0] gain_tot, loss_tot, range_tot;
  int          moves, gptr, rptr, bars_done;
  logic [31:0] last_mid;
  logic        last_seen;
  logic [31:0] bar_hi, bar_lo, bar_last, prev_close;
  logic [47:0] bar_idx;
  logic        bar_open;
  logic [31:0] atr_now;
  logic [22:0] rsi_now;

  // expected results, written on tick acceptance, read on result beats
  result_t exp_mem [EXP_DEPTH];
  int  exp_wr, exp_rd;
  int  fail_cnt;
  int  snd_idle_pct, rcv_idle_pct;
  bit  hold_off;
  int  hold_cycles;
  int  quiet_cycles;
  logic [47:0] clock_ms;   // running time base for the random sessions

  task automatic reset_model();
    period_reg = PERIOD_RESET;
    for (int i = 0; i < WIN; i++) begin
      gain_q[i] = '0; loss_q[i] = '0; range_q[i] = '0;
    end
    gain_tot = '0; loss_tot = '0; range_tot = '0;
    moves = 0; gptr = 0; rptr = 0; bars_done = 0;
    last_mid = '0; last_seen = 1'b0;
    bar_hi = '0; bar_lo = '0; bar_last = '0; prev_close = '0; bar_idx = '0;
    bar_open = 1'b0; atr_now = '0; rsi_now = RSI_MID;
  endtask

  function automatic logic [31:0] span(logic [31:0] a, logic [31:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the predictor by one tick and return the result it should give.
  function automatic result_t predict_tick(tick_t t);
    result_t r;
    logic [32:0] sum;
    logic [31:0] mid, g, l, tr;
    logic [47:0] per, idx;
    logic [63:0] num, den;
    int held;
    r = '0;
    sum = {1'b0, t.bid_price} + {1'b0, t.ask_price};
    mid = sum[32:1];
    per = (period_reg == 0) ? 48'd1 : {26'd0, period_reg};
    idx = t.time_ms / per;
    if (last_seen) begin
      g = (mid > last_mid) ? mid - last_mid : '0;
      l = (mid < last_mid) ? last_mid - mid : '0;
      gain_tot = gain_tot - gain_q[gptr] + g;
      loss_tot = loss_tot - loss_q[gptr] + l;
      gain_q[gptr] = g; loss_q[gptr] = l;
      gptr = (gptr + 1 >= WIN) ? 0 : gptr + 1;
      if (moves < WIN) moves++;
      if (moves >= WIN) begin
        if (loss_tot == 0) rsi_now = RSI_FULL;
        else begin
          num = 64'(gain_tot) * 64'd6553600;
          den = 64'(gain_tot) + 64'(loss_tot);
          rsi_now = 23'(num / den);
        end
      end
    end
    last_mid = mid; last_seen = 1'b1;
    if (!bar_open) begin
      bar_hi = mid; bar_lo = mid; bar_last = mid; bar_idx = idx; bar_open = 1'b1;
    end else if (idx != bar_idx) begin
      r.bar_closed = 1'b1;
      r.closed_high = bar_hi; r.closed_low = bar_lo; r.closed_close = bar_last;
      if (bars_done > 0) begin
        tr = bar_hi - bar_lo;
        if (span(bar_hi, prev_close) > tr) tr = span(bar_hi, prev_close);
        if (span(bar_lo, prev_close) > tr) tr = span(bar_lo, prev_close);
        range_tot = range_tot - range_q[rptr] + tr;
        range_q[rptr] = tr;
        rptr = (rptr + 1 >= WIN) ? 0 : rptr + 1;
        held = ((bars_done < 50) ? bars_done + 1 : 50) - 1;
        if (held > WIN) held = WIN;
        atr_now = (held != 0) ? 32'(range_tot / held) : '0;
      end
      prev_close = bar_last;
      if (bars_done < 50) bars_done++;
      bar_hi = mid; bar_lo = mid; bar_last = mid; bar_idx = idx;
    end else begin
      if (mid > bar_hi) bar_hi = mid;
      if (mid < bar_lo) bar_lo = mid;
      bar_last = mid;
    end
    r.bars_held = BARS_W'(bars_done);
    r.range_average = atr_now;
    r.strength_index = rsi_now;
    return r;
  endfunction

  // ---- sender: one beat per call, prediction taken on acceptance ----
  task automatic send_tick(logic [31:0] bid, logic [31:0] ask, logic [47:0] tms);
    tick_t t;
    int gap;
    t.bid_price = bid; t.ask_price = ask; t.time_ms = tms;
    gap = 0;
    while ($urandom_range(99, 0) < snd_idle_pct) gap++;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    exp_mem[exp_wr % EXP_DEPTH] = predict_tick(t);
    exp_wr++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Only written while idle; the predictor follows at the same moment.
  task automatic write_period(logic [21:0] p);
    wait_drained();
    cfg_we <= 1'b1; cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_reg = p;
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (exp_wr == exp_rd) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result beat %p", res_ch.data);
      end else begin
        exp_r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (res_ch.data !== exp_r) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected %p got %p", exp_r, res_ch.data);
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) begin
      res_ch.ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 3000) hold_off = 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
      quiet_cycles = 0;
    else if (++quiet_cycles >= WDOG_LIM) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_directed_corners();
    write_period(22'd10);
    send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0);         // first tick, top mid
    send_tick(32'h0, 32'h0, 48'd3);                        // zero mid, big loss
    send_tick(32'h0, 32'h1, 48'd5);                        // rounding down
    send_tick(32'hFFFF_FFFF, 32'h0, 48'd12);               // closes bar
    send_tick(32'h8000_0000, 32'h8000_0000, 48'd25);       // closes, first range
    send_tick(32'h1234_5678, 32'h8765_4321, 48'd4);        // time goes back
    send_tick(32'hAAAA_AAAA, 32'h5555_5555, 48'hFFFF_FFFF_FFFF); // max time
    for (int i = 0; i < 16; i++)                           // flat ticks fill ring
      send_tick(32'h0001_0000, 32'h0001_0000, 48'hFFFF_FFFF_FFFF);
    write_period(22'd0);                                   // zero acts as one
    send_tick(32'h0002_0000, 32'h0002_0000, 48'd100);
    send_tick(32'h0001_0000, 32'h0002_0000, 48'd101);
  endtask

  // A session: a price walk with ticks mostly moving forward in time, with random time jumps.
  task automatic run_session(int n, logic [21:0] p);
    logic [31:0] px, sprd;
    write_period(p);
    px = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0) px = $urandom();      // jump
      else px = px + 32'($signed($urandom_range(4096, 0)) - 2048);
      sprd = $urandom_range(255, 0);
      clock_ms = clock_ms + 48'($urandom_range(2 * p + 2, 0) / 3);
      if ($urandom_range(49, 0) == 0) clock_ms = {$urandom(), 16'($urandom())}; // noise
      send_tick(px, px + sprd, clock_ms);
    end
  endtask

  task automatic test_random_ticks();
    snd_idle_pct = 15; rcv_idle_pct = 73;
    run_session(300, 22'd5);
    snd_idle_pct = 73; rcv_idle_pct = 15;
    run_session(300, 22'd1);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    run_session(250, 22'h3F_FFFF);
  endtask

  task automatic test_backpressure();
    hold_cycles = 0;
    hold_off = 1'b1;                 // receiver holds off while the tracker stalls on a held result
    run_session(20, 22'd3600000);
    wait_drained();                  // sender pauses until all results are in
    run_session(10, 22'd60000);
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0;
    tick_ch.valid = 1'b0; tick_ch.data = '0; res_ch.ready = 1'b0;
    fail_cnt = 0; hold_off = 1'b0; hold_cycles = 0; quiet_cycles = 0;
    exp_wr = 0; exp_rd = 0;
    snd_idle_pct = 15; rcv_idle_pct = 73; clock_ms = '0;
    reset_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_corners();
    test_random_ticks();
    test_backpressure();
    wait_drained();
    if (fail_cnt == 0 && exp_wr == exp_rd) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
